/* design/ise_pkg.sv */
package ise_pkg;

    localparam int DEFAULT_CAPACITY = 1024;

    localparam int VALUE_W  = 32;
    localparam int LEFT_W   = 11;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_POP    = 1'b1;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic                      ins;
        logic                      pop;
        logic signed [VALUE_W-1:0] value;
    } op_t;

endpackage

/* design/ise_cell.sv */
module ise_cell
(
    input  logic                              clk,
    input  ise_pkg::op_t                      op,
    input  logic                              occupied,
    input  logic signed [ise_pkg::VALUE_W-1:0] left_val,
    input  logic                              left_gt,
    input  logic signed [ise_pkg::VALUE_W-1:0] right_val,
    output logic signed [ise_pkg::VALUE_W-1:0] val,
    output logic                              gt
);

    logic signed [ise_pkg::VALUE_W-1:0] val_reg;
    logic signed [ise_pkg::VALUE_W-1:0] val_next;

    // This cell holds a value strictly greater than the one being inserted,
    // so it must move one place to the right.
    assign gt  = occupied && (val_reg > op.value);
    assign val = val_reg;

    always_comb
    begin
        val_next = val_reg;
        if (op.ins)
        begin
            if (left_gt)
            begin
                val_next = left_val;
            end
            else if (gt || !occupied)
            begin
                val_next = op.value;
            end
        end
        else if (op.pop)
        begin
            val_next = right_val;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

/* design/insertion_sort_engine.sv */
// Insertion sort engine: a sorted store of signed 32-bit values held in a
// chain of compare-and-shift cells, smallest value in the first cell.
// A transaction is taken at a rising edge with start high and busy low;
// mode selects insert (value_in) or pop. Every command completes in the
// cell chain at the edge that takes it, so busy stays low and one
// transaction can be taken in every cycle.
// An insert moves every cell holding a greater value one place right and
// drops the new value into the gap; it gives no result. An insert into a
// full store is discarded and sets a sticky drop flag.
// A pop of a non-empty store shifts the whole chain one place left. Its result appears on
// value_out, status, items_left and dropped_insert with done high for
// exactly one cycle, the cycle after the pop was taken. The receiver has no
// way to stall, so results are never held. A pop of an empty store gives
// status empty and value zero. Every pop clears the drop flag.
// Reset empties the store and clears the drop flag at once; the cell
// contents themselves are not cleared and are never seen before written.
module insertion_sort_engine
#(
    parameter int CAPACITY = ise_pkg::DEFAULT_CAPACITY
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               mode,
    input  logic signed [ise_pkg::VALUE_W-1:0] value_in,
    output logic                               done,
    output logic signed [ise_pkg::VALUE_W-1:0] value_out,
    output logic                               status,
    output logic [ise_pkg::LEFT_W-1:0]         items_left,
    output logic                               dropped_insert
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          drop_reg;
    logic          drop_next;

    logic                               done_reg;
    logic signed [ise_pkg::VALUE_W-1:0] value_out_reg;
    logic                               status_reg;
    logic [ise_pkg::LEFT_W-1:0]         items_left_reg;
    logic                               dropped_reg;

    logic                               accept;
    logic                               full;
    logic                               empty;
    logic                               pop_cmd;
    logic [CW-1:0]                      count_after_pop;
    logic [CW+ise_pkg::LEFT_W-1:0]      left_ext;
    ise_pkg::op_t                       op;

    logic signed [ise_pkg::VALUE_W-1:0] cell_val [CAPACITY];
    logic                               cell_gt  [CAPACITY];

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (count_reg == CW'(CAPACITY));
    assign empty  = (count_reg == '0);

    assign pop_cmd  = accept && (mode == ise_pkg::MODE_POP);
    assign op.ins   = accept && (mode == ise_pkg::MODE_INSERT) && !full;
    assign op.pop   = pop_cmd && !empty;
    assign op.value = value_in;

    assign count_after_pop = empty ? '0 : (count_reg - CW'(1));
    assign left_ext        = {{ise_pkg::LEFT_W{1'b0}}, count_after_pop};

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [ise_pkg::VALUE_W-1:0] lv;
        logic                               lg;
        logic signed [ise_pkg::VALUE_W-1:0] rv;
        logic                               occ;

        assign occ = (CW'(i) < count_reg);

        if (i == 0)
        begin : g_first
            assign lv = '0;
            assign lg = 1'b0;
        end
        else
        begin : g_mid
            assign lv = cell_val[i-1];
            assign lg = cell_gt[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign rv = cell_val[i];
        end
        else
        begin : g_inner
            assign rv = cell_val[i+1];
        end

        ise_cell u_cell
        (
            .clk       (clk),
            .op        (op),
            .occupied  (occ),
            .left_val  (lv),
            .left_gt   (lg),
            .right_val (rv),
            .val       (cell_val[i]),
            .gt        (cell_gt[i])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        drop_next  = drop_reg;
        if (op.ins)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (op.pop)
        begin
            count_next = count_reg - CW'(1);
        end
        if (accept && (mode == ise_pkg::MODE_INSERT) && full)
        begin
            drop_next = 1'b1;
        end
        else if (pop_cmd)
        begin
            drop_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            drop_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            drop_reg  <= drop_next;
            done_reg  <= pop_cmd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_cmd)
        begin
            value_out_reg  <= empty ? '0 : cell_val[0];
            status_reg     <= empty ? ise_pkg::STATUS_EMPTY : ise_pkg::STATUS_OK;
            items_left_reg <= left_ext[ise_pkg::LEFT_W-1:0];
            dropped_reg    <= drop_reg;
        end
    end

    assign done           = done_reg;
    assign value_out      = value_out_reg;
    assign status         = status_reg;
    assign items_left     = items_left_reg;
    assign dropped_insert = dropped_reg;

endmodule
